@@ src/epd_pkg.sv @@
// Shared types, constants and controller/datapath command and status structs.
package epd_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int TS_W            = 16;
    localparam int CFG_W           = 10;
    localparam int DIST_W          = 10;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 6;

    localparam logic [CFG_W-1:0]  TICKS_RESET = CFG_W'(58);
    localparam logic [DIST_W-1:0] MAX_DIST    = DIST_W'(999);
    localparam logic [DIST_W-1:0] HUNDRED     = DIST_W'(100);
    localparam logic [DIST_W-1:0] TEN         = DIST_W'(10);
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);

    typedef struct packed {
        logic            edge_rising;
        logic [TS_W-1:0] timestamp;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
        logic [DIST_W-1:0] distance_cm;
        logic              over_range;
    } out_t;

    typedef enum logic [1:0] {
        DIG_HUND,
        DIG_TENS,
        DIG_ONES
    } digit_sel_t;

    typedef struct packed {
        logic       capture_rise;
        logic       start_div;
        logic       div_step;
        logic       start_conv;
        logic       conv_step;
        logic       load_out;
        digit_sel_t sel;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic conv_done;
        logic hund_nz;
        logic tens_nz;
    } dp_stat_t;

endpackage

@@ src/epd_ctrl.sv @@
// Controller state machine: sequences capture, division, digit split and emission.
module epd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              edge_rising,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  epd_pkg::dp_stat_t stat,
    output epd_pkg::dp_cmd_t  cmd
);
    import epd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_FINISH,
        S_CONVERT,
        S_EMIT_HUND,
        S_EMIT_TENS,
        S_EMIT_ONES
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        cmd.capture_rise = 1'b0;
        cmd.start_div    = 1'b0;
        cmd.div_step     = 1'b0;
        cmd.start_conv   = 1'b0;
        cmd.conv_step    = 1'b0;
        cmd.load_out     = 1'b0;
        cmd.sel          = DIG_ONES;
        cmd.last         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (edge_rising)
                        cmd.capture_rise = 1'b1;
                    else
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.start_conv = 1'b1;
                state_next     = S_CONVERT;
            end
            S_CONVERT:
            begin
                if (!stat.conv_done)
                    cmd.conv_step = 1'b1;
                else if (stat.hund_nz)
                    state_next = S_EMIT_HUND;
                else if (stat.tens_nz)
                    state_next = S_EMIT_TENS;
                else
                    state_next = S_EMIT_ONES;
            end
            S_EMIT_HUND:
            begin
                cmd.sel = DIG_HUND;
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_EMIT_TENS;
                end
            end
            S_EMIT_TENS:
            begin
                cmd.sel = DIG_TENS;
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_EMIT_ONES;
                end
            end
            S_EMIT_ONES:
            begin
                cmd.sel  = DIG_ONES;
                cmd.last = 1'b1;
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/epd_datapath.sv @@
// Datapath: rise capture, restoring divider, decimal split and output register.
module epd_datapath #(
    parameter int TIMER_WIDTH = epd_pkg::TIMER_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  epd_pkg::in_t              in_data,
    input  logic                      cfg_we,
    input  logic [epd_pkg::CFG_W-1:0] cfg_data,
    input  epd_pkg::dp_cmd_t          cmd,
    output epd_pkg::dp_stat_t         stat,
    output epd_pkg::out_t             out_data
);
    import epd_pkg::*;

    localparam int CW = $clog2(TIMER_WIDTH);
    localparam int QW = (TIMER_WIDTH > DIST_W) ? TIMER_WIDTH : DIST_W;

    logic [TIMER_WIDTH-1:0] rise_time_reg;
    logic [CFG_W-1:0]       ticks_reg;
    logic [CFG_W-1:0]       divisor_reg;
    logic [CFG_W-1:0]       rem_reg;
    logic [TIMER_WIDTH-1:0] quo_reg;
    logic [CW-1:0]          cnt_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic                   ovr_reg;
    logic [DIST_W-1:0]      bin_reg;
    logic [DIGIT_W-1:0]     hund_reg;
    logic [DIGIT_W-1:0]     tens_reg;
    out_t                   out_reg;

    logic [TIMER_WIDTH-1:0] ts_tw;
    logic [TIMER_WIDTH-1:0] elapsed;
    logic [CFG_W:0]         trial;
    logic [CFG_W:0]         diff;
    logic                   fits;
    logic [CFG_W-1:0]       rem_step;
    logic [QW-1:0]          quo_ext;
    logic                   q_over;
    logic [DIST_W-1:0]      dist_calc;
    logic                   ge100;
    logic                   ge10;
    logic [DIGIT_W-1:0]     digit;

    assign ts_tw   = TIMER_WIDTH'(in_data.timestamp);
    assign elapsed = ts_tw - rise_time_reg;

    // One quotient bit per step: shift in the next dividend bit, subtract if it fits.
    assign trial    = {rem_reg, quo_reg[TIMER_WIDTH-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign fits     = trial >= {1'b0, divisor_reg};
    assign rem_step = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];

    // Quotient plus one exceeds the limit exactly when the quotient reaches it.
    assign quo_ext   = QW'(quo_reg);
    assign q_over    = quo_ext >= QW'(MAX_DIST);
    assign dist_calc = q_over ? MAX_DIST : quo_ext[DIST_W-1:0] + DIST_W'(1);

    assign ge100 = bin_reg >= HUNDRED;
    assign ge10  = bin_reg >= TEN;

    always_comb
    begin
        unique case (cmd.sel)
            DIG_HUND: digit = hund_reg;
            DIG_TENS: digit = tens_reg;
            DIG_ONES: digit = bin_reg[DIGIT_W-1:0];
            default:  digit = bin_reg[DIGIT_W-1:0];
        endcase
    end

    assign stat.div_done  = (cnt_reg == '0);
    assign stat.conv_done = !ge10;
    assign stat.hund_nz   = (hund_reg != '0);
    assign stat.tens_nz   = (tens_reg != '0);
    assign out_data       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_time_reg <= '0;
            ticks_reg     <= TICKS_RESET;
        end
        else
        begin
            if (cmd.capture_rise)
                rise_time_reg <= ts_tw;
            if (cfg_we)
                ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            quo_reg     <= elapsed;
            rem_reg     <= '0;
            cnt_reg     <= CW'(TIMER_WIDTH - 1);
            divisor_reg <= (ticks_reg == '0) ? CFG_W'(1) : ticks_reg;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[TIMER_WIDTH-2:0], fits};
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg - CW'(1);
        end

        if (cmd.start_conv)
        begin
            dist_reg <= dist_calc;
            ovr_reg  <= q_over;
            bin_reg  <= dist_calc;
            hund_reg <= '0;
            tens_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            // Peel hundreds first, then tens; what is left is the ones digit.
            if (ge100)
            begin
                bin_reg  <= bin_reg - HUNDRED;
                hund_reg <= hund_reg + DIGIT_W'(1);
            end
            else
            begin
                bin_reg  <= bin_reg - TEN;
                tens_reg <= tens_reg + DIGIT_W'(1);
            end
        end

        if (cmd.load_out)
        begin
            out_reg.digit_char  <= ASCII_ZERO + CHAR_W'(digit);
            out_reg.last_digit  <= cmd.last;
            out_reg.distance_cm <= dist_reg;
            out_reg.over_range  <= ovr_reg;
        end
    end

endmodule

@@ src/echo_pulse_distance_digits.sv @@
// Top level: echo pulse width to distance, emitted as ASCII decimal digits.
//
// Feed echo edge events on the input channel, each with the free-running timer
// count captured at the edge. A rising edge records its timestamp and yields
// no result. A falling edge measures the elapsed ticks since the last rising
// edge (modulo 2^TIMER_WIDTH), divides by ticks_per_cm (a divisor of zero acts
// as one) and adds one; distances above 999 cm clamp to 999 with over_range
// set. The distance then leaves as one to three ASCII digit transfers, most
// significant first, no leading zeros, with last_digit on the final one;
// distance_cm and over_range repeat on every digit. A falling edge occupies
// the block through a start step, TIMER_WIDTH steps of the one-bit-per-cycle
// restoring divider, a finish step, up to 18 subtract steps of the decimal
// split (one per hundred and per ten), and one load of each digit into the
// output register, each load waiting while the output is stalled. The final
// digit may still wait in the output register while the next edge is taken.
// ticks_per_cm resets to 58; write it with the config channel only while the
// block is idle.
module echo_pulse_distance_digits #(
    parameter int TIMER_WIDTH = epd_pkg::TIMER_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  epd_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output epd_pkg::out_t             out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [epd_pkg::CFG_W-1:0] cfg_data
);
    import epd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     cfg_we;

    // The register is a plain flop: take every config transfer at once.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    epd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .edge_rising (in_data.edge_rising),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    epd_datapath #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

@@ dv/tb_echo_pulse_distance_digits.sv @@
`timescale 1ns / 1ps
// Testbench for echo_pulse_distance_digits: directed edge table, then random echo pairs.
module tb_echo_pulse_distance_digits;
    import epd_pkg::*;

    // Drain wait covering the busy time of a falling edge, with margin.
    localparam int DRAIN_CYCLES = 48;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Minimum input edges per divisor setting in the random part (3 phases x 3 settings).
    localparam int BLOCK_ITEMS  = 43;

    typedef enum logic [1:0]
    {
        ROW_RISE,
        ROW_FALL,
        ROW_CFG
    } row_kind_e;

    // One directed step: an edge with its timestamp, or a divisor write.
    // Where typed is set, dist_cm/over hold the expected distance read off by hand.
    typedef struct packed
    {
        row_kind_e         kind;
        logic [TS_W-1:0]   value;
        logic              typed;
        logic [DIST_W-1:0] dist_cm;
        logic              over;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // Divisor at its reset value 58; no rising edge seen yet, so measure from 0.
        '{ROW_FALL, 16'h0000, 1'b1, 10'd1,   1'b0},
        '{ROW_FALL, 16'h0039, 1'b1, 10'd1,   1'b0},  // 57 ticks: just under one cm
        '{ROW_FALL, 16'h003A, 1'b1, 10'd2,   1'b0},  // 58 ticks: first step
        // Repeated rising edges: the later one wins.
        '{ROW_RISE, 16'h0064, 1'b0, 10'd0,   1'b0},
        '{ROW_RISE, 16'hFFF0, 1'b0, 10'd0,   1'b0},
        '{ROW_FALL, 16'h0010, 1'b1, 10'd1,   1'b0},  // timer wrap, 32 ticks
        '{ROW_FALL, 16'h0200, 1'b0, 10'd0,   1'b0},  // repeated fall, same rise
        // Divisor of one: distance equals elapsed + 1.
        '{ROW_CFG,  16'd1,    1'b0, 10'd0,   1'b0},
        '{ROW_RISE, 16'h0000, 1'b0, 10'd0,   1'b0},
        '{ROW_FALL, 16'hFFFF, 1'b1, 10'd999, 1'b1},  // longest pulse, saturates
        '{ROW_FALL, 16'h03E6, 1'b1, 10'd999, 1'b0},  // exactly 999
        '{ROW_FALL, 16'h03E7, 1'b1, 10'd999, 1'b1},  // 1000 clamps
        '{ROW_FALL, 16'h0063, 1'b1, 10'd100, 1'b0},  // three digits with zeros
        '{ROW_FALL, 16'h0008, 1'b1, 10'd9,   1'b0},
        // Zero divisor behaves as one.
        '{ROW_CFG,  16'd0,    1'b0, 10'd0,   1'b0},
        '{ROW_FALL, 16'h0005, 1'b1, 10'd6,   1'b0},
        // Largest divisor.
        '{ROW_CFG,  16'd1023, 1'b0, 10'd0,   1'b0},
        '{ROW_RISE, 16'hFFFF, 1'b0, 10'd0,   1'b0},
        '{ROW_FALL, 16'hFFFE, 1'b1, 10'd65,  1'b0},  // 65535 ticks through the wrap
        '{ROW_FALL, 16'hFFFF, 1'b1, 10'd1,   1'b0},  // zero-width pulse
        '{ROW_RISE, 16'h5555, 1'b0, 10'd0,   1'b0},
        '{ROW_FALL, 16'hAAAA, 1'b0, 10'd0,   1'b0},
        '{ROW_CFG,  16'd58,   1'b0, 10'd0,   1'b0},
        '{ROW_FALL, 16'h1234, 1'b0, 10'd0,   1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_t               in_data;
    logic              out_valid;
    logic              out_ready;
    out_t              out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    // Predictor state: latest rising timestamp and the divisor in force.
    logic [TS_W-1:0]   last_rise_ts;
    logic [CFG_W-1:0]  cm_divisor;
    // Digits still owed by the block, oldest first.
    out_t              digit_q[$];

    int                mismatches;
    int                stall_cycles;
    int                send_idle_pct;
    int                recv_idle_pct;

    echo_pulse_distance_digits DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the saturated distance of a falling edge from the held rise time.
    function automatic void echo_to_distance(input logic [TS_W-1:0] fall_ts,
                                             output logic [DIST_W-1:0] dist_cm,
                                             output logic over);
        logic [TS_W-1:0]  elapsed;
        logic [CFG_W-1:0] div;
        logic [TS_W:0]    raw;
        // Subtraction at timer width wraps on its own.
        elapsed = fall_ts - last_rise_ts;
        div     = (cm_divisor == '0) ? CFG_W'(1) : cm_divisor;
        raw     = {1'b0, elapsed / TS_W'(div)} + 1'b1;
        over    = (raw > (TS_W+1)'(MAX_DIST));
        dist_cm = over ? MAX_DIST : raw[DIST_W-1:0];
    endfunction

    // Split a distance into ASCII digits, no leading zeros, and queue them.
    function automatic void queue_digits(input logic [DIST_W-1:0] dist_cm, input logic over);
        int   place[3];
        int   first;
        out_t d;
        place[0] = int'(dist_cm) / 100;
        place[1] = (int'(dist_cm) / 10) % 10;
        place[2] = int'(dist_cm) % 10;
        first    = (dist_cm >= HUNDRED) ? 0 : (dist_cm >= TEN) ? 1 : 2;
        for (int k = first; k < 3; k++)
        begin
            d.digit_char  = ASCII_ZERO + CHAR_W'(place[k]);
            d.last_digit  = (k == 2);
            d.distance_cm = dist_cm;
            d.over_range  = over;
            digit_q.push_back(d);
        end
    endfunction

    // Present one edge and hold it until the transfer; on the transfer update
    // the predictor. Returns in the step of the transfer with in_valid still
    // high, so the caller must either present the next edge or drop valid
    // before time advances.
    task automatic send_edge(input logic rising, input logic [TS_W-1:0] ts,
                             input logic typed, input logic [DIST_W-1:0] tdist,
                             input logic tover);
        logic [DIST_W-1:0] dist_cm;
        logic              over;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid              <= 1'b1;
        in_data.edge_rising   <= rising;
        in_data.timestamp     <= ts;
        do @(posedge clk); while (!in_ready);
        if (rising)
        begin
            last_rise_ts = ts;
        end
        else if (typed)
        begin
            queue_digits(tdist, tover);
        end
        else
        begin
            echo_to_distance(ts, dist_cm, over);
            queue_digits(dist_cm, over);
        end
    endtask

    // Write the divisor only once the block is idle: drop the edge channel,
    // let every owed digit drain, wait out a possible trailing computation.
    task automatic write_divisor(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (digit_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cm_divisor = value;
    endtask

    // Receiver: stall at random with the current idle percentage.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check each digit transfer against the oldest owed digit, field by field.
    always @(posedge clk)
    begin : digit_check
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (digit_q.size() == 0)
            begin
                $error("digit transfer with nothing owed: %h", out_data);
                mismatches++;
            end
            else
            begin
                want = digit_q.pop_front();
                if (out_data.digit_char !== want.digit_char)
                begin
                    $error("digit_char: expected %0d, got %0d",
                           want.digit_char, out_data.digit_char);
                    mismatches++;
                end
                if (out_data.last_digit !== want.last_digit)
                begin
                    $error("last_digit: expected %0d, got %0d",
                           want.last_digit, out_data.last_digit);
                    mismatches++;
                end
                if (out_data.distance_cm !== want.distance_cm)
                begin
                    $error("distance_cm: expected %0d, got %0d",
                           want.distance_cm, out_data.distance_cm);
                    mismatches++;
                end
                if (out_data.over_range !== want.over_range)
                begin
                    $error("over_range: expected %0d, got %0d",
                           want.over_range, out_data.over_range);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Hang guard.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int               blk_items;
        int               eff_div;
        int               reach;
        int               span;
        logic [TS_W-1:0]  rise_ts;
        logic [CFG_W-1:0] div_pick;

        // Drive every input to a known value from time zero.
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        mismatches    = 0;
        stall_cycles  = 0;
        send_idle_pct = 19;
        recv_idle_pct = 74;
        last_rise_ts  = '0;
        cm_divisor    = TICKS_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: walk the table.
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_divisor(dir_tab[i].value[CFG_W-1:0]);
            else
                send_edge(dir_tab[i].kind == ROW_RISE, dir_tab[i].value,
                          dir_tab[i].typed, dir_tab[i].dist_cm, dir_tab[i].over);
        end

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 19 : 0;
            for (int blk = 0; blk < 3; blk++)
            begin
                // Pick a divisor: extremes, zero, one that lets all digit counts occur, or any other.
                case ($urandom_range(0, 5))
                    0:       div_pick = CFG_W'(1);
                    1:       div_pick = '1;
                    2:       div_pick = '0;
                    3:       div_pick = CFG_W'($urandom_range(2, 64));
                    default: div_pick = CFG_W'($urandom_range(2, 1022));
                endcase
                write_divisor(div_pick);

                blk_items = 0;
                while (blk_items < BLOCK_ITEMS)
                begin
                    if ($urandom_range(0, 99) < 15)
                    begin
                        // Noise: a lone edge of either kind, random timestamp.
                        send_edge(1'($urandom_range(0, 1)), TS_W'($urandom_range(0, 65535)),
                                  1'b0, '0, 1'b0);
                        blk_items++;
                    end
                    else
                    begin
                        // Well-formed pulse aimed at a digit-count class.
                        eff_div = (cm_divisor == '0) ? 1 : int'(cm_divisor);
                        case ($urandom_range(0, 3))
                            0:       reach = $urandom_range(1, 9);
                            1:       reach = $urandom_range(10, 99);
                            2:       reach = $urandom_range(100, 999);
                            default: reach = 1000;
                        endcase
                        if (reach == 1000 && 999 * eff_div <= 65535)
                            span = $urandom_range(999 * eff_div, 65535);
                        else
                            span = (reach - 1) * eff_div + $urandom_range(0, eff_div - 1);
                        // Out of reach at this divisor: fall back to any width.
                        if (span > 65535)
                            span = $urandom_range(0, 65535);
                        rise_ts = TS_W'($urandom_range(0, 65535));
                        send_edge(1'b1, rise_ts, 1'b0, '0, 1'b0);
                        send_edge(1'b0, rise_ts + TS_W'(span), 1'b0, '0, 1'b0);
                        blk_items += 2;
                    end
                end
            end
        end

        // Drop valid, drain owed digits, then give the block time to misbehave.
        in_valid <= 1'b0;
        while (digit_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
src/epd_pkg.sv
src/epd_ctrl.sv
src/epd_datapath.sv
src/echo_pulse_distance_digits.sv
dv/tb_echo_pulse_distance_digits.sv
